// File: design/scc_pkg.sv
`timescale 1ns / 1ps
package scc_pkg;

  // default coordinate width and fraction bits
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;

  // width of the on-segment tolerance register
  localparam int TOL_W = 16;

endpackage

// File: design/scc_if.sv
`timescale 1ns / 1ps
// query channel: one segment and one circle per request
interface scc_in_if #(
  parameter int CB = scc_pkg::COORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] start_x;
  logic signed [CB-1:0] start_y;
  logic signed [CB-1:0] end_x;
  logic signed [CB-1:0] end_y;
  logic signed [CB-1:0] centre_x;
  logic signed [CB-1:0] centre_y;
  logic        [CB-2:0] radius;

  modport source (
    output valid, start_x, start_y, end_x, end_y, centre_x, centre_y, radius,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, centre_x, centre_y, radius,
    output ready
  );
endinterface

// result channel: one hit flag per request
interface scc_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// File: design/segment_circle_collision_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// in_req    in   valid / ready    start/end/centre x,y (signed), radius
// out_req   out  valid / ready    hit
// cfg       in   cfg_we           cfg_wdata -> on-segment tolerance
//
// One request per cycle sustained while out_req.ready is high. The pipeline holds
// the bit-per-stage divider (COORD_BITS+1 stages) and the three
// digit-per-stage square-root lanes (COORD_BITS+2 stages).
// Reset (synchronous, active low) empties the pipeline and loads tolerance 26.
// A stall fills bubbles first; in_req.ready drops only when every stage holds a request or rst_n is low.
module segment_circle_collision_core #(
  parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = scc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  scc_in_if.sink                     in_req,
  scc_out_if.source                  out_req,
  input  logic                       cfg_we,
  input  logic [scc_pkg::TOL_W-1:0]  cfg_wdata
);
  import scc_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int SQW  = 2 * CB;
  localparam int R2W  = 2 * CB - 2;
  localparam int LW   = 2 * CB + 1;
  localparam int DMW  = LW;
  localparam int H    = CB + 1;
  localparam int NW   = 3 * CB + 2;
  localparam int QW   = CB + 1;
  localparam int EW   = CB + 2;
  localparam int EM   = CB + 1;
  localparam int SW   = 2 * CB + 2;
  localparam int VW   = 2 * CB + 3;
  localparam int RW   = CB + 2;
  localparam int OPW  = 2 * RW;
  localparam int CW   = ((RW + 2) > TOL_W ? (RW + 2) : TOL_W) + 1;
  localparam int NL   = 3;
  localparam int LN_D1  = 0;
  localparam int LN_D2  = 1;
  localparam int LN_LEN = 2;

  localparam int ST_S1 = 0;
  localparam int ST_S2 = 1;
  localparam int ST_S3 = 2;
  localparam int ST_S4 = 3;
  localparam int ST_S5 = 4;
  localparam int ST_D0 = 5;
  localparam int ST_A  = ST_D0 + QW;
  localparam int ST_B  = ST_A + 1;
  localparam int ST_C  = ST_B + 1;
  localparam int ST_Q0 = ST_C + 1;
  localparam int ST_R  = ST_Q0 + RW;
  localparam int ST_O  = ST_R + 1;
  localparam int NS    = ST_O + 1;
  localparam int SN    = ST_C - ST_S3;
  localparam int TN    = ST_O - ST_C;

  localparam logic [TOL_W-1:0] TOL_RST = TOL_W'((2 ** FRAC_BITS + 5) / 10);

  typedef struct packed {
    logic                 endhit;
    logic                 zero;
    logic                 negx;
    logic                 negy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] ccx;
    logic signed [DW-1:0] ccy;
    logic [R2W-1:0]       r2;
    logic [LW-1:0]        len2;
  } side_t;

  typedef struct packed {
    logic endhit;
    logic zero;
    logic chit;
  } tail_t;

  function automatic logic [CB-1:0] mag_d(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = v[DW-1] ? -v : v;
    return a[CB-1:0];
  endfunction

  function automatic logic [EM-1:0] mag_e(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] a;
    a = v[EW-1] ? -v : v;
    return a[EM-1:0];
  endfunction

  // tolerance register
  logic [TOL_W-1:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RST;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // stage valids and advance enables: a stage moves when it or any later stage has room, or the output is ready
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_req.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_req.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_req.ready = en[0] && rst_n;

  // stage 1: coordinate differences and magnitudes
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_ccx_r, s1_ccy_r;
  logic [CB-1:0] s1_msx_r, s1_msy_r, s1_mex_r, s1_mey_r;
  logic [CB-1:0] s1_mdx_r, s1_mdy_r, s1_mcx_r, s1_mcy_r;
  logic [CB-2:0] s1_rad_r;
  logic signed [DW-1:0] s1_dsx, s1_dsy, s1_dex, s1_dey, s1_dx, s1_dy, s1_ccx, s1_ccy;

  always_comb begin
    s1_dsx = DW'(in_req.start_x) - DW'(in_req.centre_x);
    s1_dsy = DW'(in_req.start_y) - DW'(in_req.centre_y);
    s1_dex = DW'(in_req.end_x) - DW'(in_req.centre_x);
    s1_dey = DW'(in_req.end_y) - DW'(in_req.centre_y);
    s1_dx  = DW'(in_req.end_x) - DW'(in_req.start_x);
    s1_dy  = DW'(in_req.end_y) - DW'(in_req.start_y);
    s1_ccx = DW'(in_req.centre_x) - DW'(in_req.start_x);
    s1_ccy = DW'(in_req.centre_y) - DW'(in_req.start_y);
  end

  always_ff @(posedge clk) begin
    if (en[ST_S1]) begin
      s1_dx_r  <= s1_dx;
      s1_dy_r  <= s1_dy;
      s1_ccx_r <= s1_ccx;
      s1_ccy_r <= s1_ccy;
      s1_msx_r <= mag_d(s1_dsx);
      s1_msy_r <= mag_d(s1_dsy);
      s1_mex_r <= mag_d(s1_dex);
      s1_mey_r <= mag_d(s1_dey);
      s1_mdx_r <= mag_d(s1_dx);
      s1_mdy_r <= mag_d(s1_dy);
      s1_mcx_r <= mag_d(s1_ccx);
      s1_mcy_r <= mag_d(s1_ccy);
      s1_rad_r <= in_req.radius;
    end
  end

  // stage 2: squares and dot-product terms
  logic [SQW-1:0] s2_sqsx_r, s2_sqsy_r, s2_sqex_r, s2_sqey_r;
  logic [SQW-1:0] s2_dx2_r, s2_dy2_r, s2_m1_r, s2_m2_r;
  logic [R2W-1:0] s2_r2_r;
  logic s2_n1_r, s2_n2_r;
  logic signed [DW-1:0] s2_dx_r, s2_dy_r, s2_ccx_r, s2_ccy_r;
  logic [CB-1:0] s2_mdx_r, s2_mdy_r;

  always_ff @(posedge clk) begin
    if (en[ST_S2]) begin
      s2_sqsx_r <= SQW'(s1_msx_r) * SQW'(s1_msx_r);
      s2_sqsy_r <= SQW'(s1_msy_r) * SQW'(s1_msy_r);
      s2_sqex_r <= SQW'(s1_mex_r) * SQW'(s1_mex_r);
      s2_sqey_r <= SQW'(s1_mey_r) * SQW'(s1_mey_r);
      s2_dx2_r  <= SQW'(s1_mdx_r) * SQW'(s1_mdx_r);
      s2_dy2_r  <= SQW'(s1_mdy_r) * SQW'(s1_mdy_r);
      s2_m1_r   <= SQW'(s1_mcx_r) * SQW'(s1_mdx_r);
      s2_m2_r   <= SQW'(s1_mcy_r) * SQW'(s1_mdy_r);
      s2_r2_r   <= R2W'(s1_rad_r) * R2W'(s1_rad_r);
      s2_n1_r   <= s1_ccx_r[DW-1] ^ s1_dx_r[DW-1];
      s2_n2_r   <= s1_ccy_r[DW-1] ^ s1_dy_r[DW-1];
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_ccx_r  <= s1_ccx_r;
      s2_ccy_r  <= s1_ccy_r;
      s2_mdx_r  <= s1_mdx_r;
      s2_mdy_r  <= s1_mdy_r;
    end
  end

  // stage 3: endpoint test, squared length, signed dot product
  side_t side_r [SN];
  logic [DMW-1:0] s3_dmag_r;
  logic [CB-1:0]  s3_mdx_r, s3_mdy_r;
  side_t          s3_side;
  logic [LW-1:0]  s3_ss, s3_se, s3_m1, s3_m2;
  logic [DMW-1:0] s3_dmag;
  logic           s3_dneg;

  always_comb begin
    s3_ss = LW'(s2_sqsx_r) + LW'(s2_sqsy_r);
    s3_se = LW'(s2_sqex_r) + LW'(s2_sqey_r);
    s3_m1 = LW'(s2_m1_r);
    s3_m2 = LW'(s2_m2_r);
    priority if (s2_n1_r == s2_n2_r) begin
      s3_dmag = s3_m1 + s3_m2;
      s3_dneg = s2_n1_r;
    end else if (s3_m1 >= s3_m2) begin
      s3_dmag = s3_m1 - s3_m2;
      s3_dneg = s2_n1_r;
    end else begin
      s3_dmag = s3_m2 - s3_m1;
      s3_dneg = s2_n2_r;
    end
    s3_side.endhit = (s3_ss <= LW'(s2_r2_r)) || (s3_se <= LW'(s2_r2_r));
    s3_side.len2   = LW'(s2_dx2_r) + LW'(s2_dy2_r);
    s3_side.zero   = (s3_side.len2 == '0);
    s3_side.negx   = s3_dneg ^ s2_dx_r[DW-1];
    s3_side.negy   = s3_dneg ^ s2_dy_r[DW-1];
    s3_side.dx     = s2_dx_r;
    s3_side.dy     = s2_dy_r;
    s3_side.ccx    = s2_ccx_r;
    s3_side.ccy    = s2_ccy_r;
    s3_side.r2     = s2_r2_r;
  end

  always_ff @(posedge clk) begin
    if (en[ST_S3]) begin
      side_r[0] <= s3_side;
      s3_dmag_r <= s3_dmag;
      s3_mdx_r  <= s2_mdx_r;
      s3_mdy_r  <= s2_mdy_r;
    end
  end

  // carry the side data down the pipe
  for (genvar j = 1; j < SN; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[ST_S3+j]) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // stage 4: numerator partial products
  logic [H+CB-1:0] s4_pxl_r, s4_pyl_r;
  logic [SQW-1:0]  s4_pxh_r, s4_pyh_r;
  always_ff @(posedge clk) begin
    if (en[ST_S4]) begin
      s4_pxl_r <= (H+CB)'(s3_dmag_r[H-1:0]) * (H+CB)'(s3_mdx_r);
      s4_pyl_r <= (H+CB)'(s3_dmag_r[H-1:0]) * (H+CB)'(s3_mdy_r);
      s4_pxh_r <= SQW'(s3_dmag_r[DMW-1:H]) * SQW'(s3_mdx_r);
      s4_pyh_r <= SQW'(s3_dmag_r[DMW-1:H]) * SQW'(s3_mdy_r);
    end
  end

  // stage 5: join partial products and add half the divisor for rounding
  logic [NW-1:0] remx_r [QW];
  logic [NW-1:0] remy_r [QW];
  logic [QW-1:0] qx_r [QW];
  logic [QW-1:0] qy_r [QW];
  always_ff @(posedge clk) begin
    if (en[ST_S5]) begin
      remx_r[0] <= NW'(s4_pxl_r) + (NW'(s4_pxh_r) << H) + NW'(side_r[1].len2 >> 1);
      remy_r[0] <= NW'(s4_pyl_r) + (NW'(s4_pyh_r) << H) + NW'(side_r[1].len2 >> 1);
    end
  end

  // divider: one quotient bit per stage, both axes side by side
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [NW-1:0] trial;
    logic          gex, gey;
    logic [QW-1:0] qxi, qyi;
    always_comb begin
      trial = NW'(side_r[2+k].len2) << SH;
      gex   = remx_r[k] >= trial;
      gey   = remy_r[k] >= trial;
      qxi   = (k == 0) ? '0 : qx_r[(k == 0) ? 0 : k-1];
      qyi   = (k == 0) ? '0 : qy_r[(k == 0) ? 0 : k-1];
    end
    always_ff @(posedge clk) begin
      if (en[ST_D0+k]) begin
        qx_r[k] <= qxi | (QW'(gex) << SH);
        qy_r[k] <= qyi | (QW'(gey) << SH);
      end
    end
    if (k + 1 < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[ST_D0+k]) begin
          remx_r[k+1] <= gex ? remx_r[k] - trial : remx_r[k];
          remy_r[k+1] <= gey ? remy_r[k] - trial : remy_r[k];
        end
      end
    end
  end

  // stage A: projected offsets and their distances to end and centre
  logic [QW-1:0] a_mox_r, a_moy_r;
  logic [EM-1:0] a_mxe_r, a_mye_r, a_mxc_r, a_myc_r;
  logic signed [EW-1:0] a_qxs, a_qys, a_offx, a_offy;
  side_t a_side;
  always_comb begin
    a_side = side_r[QW+2];
    a_qxs  = $signed(EW'(qx_r[QW-1]));
    a_qys  = $signed(EW'(qy_r[QW-1]));
    a_offx = a_side.negx ? -a_qxs : a_qxs;
    a_offy = a_side.negy ? -a_qys : a_qys;
  end

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      a_mox_r <= qx_r[QW-1];
      a_moy_r <= qy_r[QW-1];
      a_mxe_r <= mag_e(a_offx - EW'(a_side.dx));
      a_mye_r <= mag_e(a_offy - EW'(a_side.dy));
      a_mxc_r <= mag_e(a_offx - EW'(a_side.ccx));
      a_myc_r <= mag_e(a_offy - EW'(a_side.ccy));
    end
  end

  // stage B: squares of the offsets
  logic [SW-1:0] b_sx_r, b_sy_r, b_ex_r, b_ey_r, b_cx_r, b_cy_r;
  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      b_sx_r <= SW'(a_mox_r) * SW'(a_mox_r);
      b_sy_r <= SW'(a_moy_r) * SW'(a_moy_r);
      b_ex_r <= SW'(a_mxe_r) * SW'(a_mxe_r);
      b_ey_r <= SW'(a_mye_r) * SW'(a_mye_r);
      b_cx_r <= SW'(a_mxc_r) * SW'(a_mxc_r);
      b_cy_r <= SW'(a_myc_r) * SW'(a_myc_r);
    end
  end

  // stage C: squared distances, circle test, load the root lanes
  tail_t          tail_r [TN];
  logic [OPW-1:0] op_r   [NL][RW];
  logic [RW+1:0]  rem_r  [NL][RW];
  logic [RW-1:0]  root_r [NL][RW];
  logic [VW-1:0]  c_v [NL];
  logic [VW-1:0]  c_vc;
  always_comb begin
    c_v[LN_D1]  = VW'(b_sx_r) + VW'(b_sy_r);
    c_v[LN_D2]  = VW'(b_ex_r) + VW'(b_ey_r);
    c_v[LN_LEN] = VW'(side_r[SN-1].len2);
    c_vc        = VW'(b_cx_r) + VW'(b_cy_r);
  end

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      tail_r[0].endhit   <= side_r[SN-1].endhit;
      tail_r[0].zero     <= side_r[SN-1].zero;
      tail_r[0].chit     <= c_vc <= VW'(side_r[SN-1].r2);
      op_r[LN_D1][0]     <= OPW'(c_v[LN_D1]);
      op_r[LN_D2][0]     <= OPW'(c_v[LN_D2]);
      op_r[LN_LEN][0]    <= OPW'(c_v[LN_LEN]);
    end
  end

  for (genvar j = 1; j < TN; j++) begin : g_tail
    always_ff @(posedge clk) begin
      if (en[ST_C+j]) begin
        tail_r[j] <= tail_r[j-1];
      end
    end
  end

  // square roots: one root bit per stage in each lane
  for (genvar l = 0; l < NL; l++) begin : g_lane
    for (genvar j = 0; j < RW; j++) begin : g_sq
      localparam int BI = RW - 1 - j;
      logic [RW+1:0] remi, remt, trial;
      logic [RW-1:0] rooti;
      logic          ge;
      always_comb begin
        remi  = (j == 0) ? '0 : rem_r[l][(j == 0) ? 0 : j-1];
        rooti = (j == 0) ? '0 : root_r[l][(j == 0) ? 0 : j-1];
        remt  = {remi[RW-1:0], op_r[l][j][2*BI+1:2*BI]};
        trial = {rooti, 2'b01};
        ge    = remt >= trial;
      end
      always_ff @(posedge clk) begin
        if (en[ST_Q0+j]) begin
          rem_r[l][j]  <= ge ? remt - trial : remt;
          root_r[l][j] <= {rooti[RW-2:0], ge};
        end
      end
      if (j + 1 < RW) begin : g_op
        always_ff @(posedge clk) begin
          if (en[ST_Q0+j]) begin
            op_r[l][j+1] <= op_r[l][j];
          end
        end
      end
    end
  end

  // stage R: round each root to nearest
  logic [RW:0] d_r [NL];
  always_ff @(posedge clk) begin
    if (en[ST_R]) begin
      for (int l = 0; l < NL; l++) begin
        d_r[l] <= (RW+1)'(root_r[l][RW-1]) +
                  (RW+1)'(rem_r[l][RW-1] > (RW+2)'(root_r[l][RW-1]));
      end
    end
  end

  // output stage: on-segment window and final hit
  logic [CW-1:0] o_sum, o_len, o_tol;
  logic          o_onseg;
  logic          hit_r;
  always_comb begin
    o_sum   = CW'(d_r[LN_D1]) + CW'(d_r[LN_D2]);
    o_len   = CW'(d_r[LN_LEN]);
    o_tol   = CW'(tol_r);
    o_onseg = (o_sum + o_tol >= o_len) && (o_sum <= o_len + o_tol);
  end

  always_ff @(posedge clk) begin
    if (en[ST_O]) begin
      hit_r <= tail_r[TN-1].endhit ||
               (!tail_r[TN-1].zero && o_onseg && tail_r[TN-1].chit);
    end
  end

  assign out_req.valid = v_r[ST_O];
  assign out_req.hit   = hit_r;

  // input stalls only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (&v_r))
    else $error("input stalled with a free stage");

  // root remainder stays within twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_Q0+RW-1] |->
      rem_r[LN_LEN][RW-1] <= (RW+2)'({root_r[LN_LEN][RW-1], 1'b0}))
    else $error("square-root remainder out of range");

  // reset loads the default tolerance
  a_tol_reset: assert property (@(posedge clk)
    !rst_n |=> (tol_r == TOL_RST) || $past(cfg_we) && $past(rst_n))
    else $error("tolerance not at reset value");

endmodule

// File: verif/scc_tb_if.sv
`timescale 1ns / 1ps
// Interfaces come from the design; this file keeps the build order of the form.
// Bundled request item used by the testbench.
package scc_tb_pkg;
  typedef struct {
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic signed [23:0] centre_x;
    logic signed [23:0] centre_y;
    logic        [22:0] radius;
  } seg_query_t;
endpackage

// File: verif/testbench.sv
`timescale 1ns / 1ps
import scc_tb_pkg::*;

// Tracks expected hit flags and compares them with the results as they come back.
class hit_scoreboard;
  bit expected_hits[$];
  int n_errors;
  logic [15:0] tol;

  function new();
    tol = 16'd26;
    n_errors = 0;
  endfunction

  // Square root of v, rounded to the nearest integer.
  function automatic longint unsigned round_sqrt(logic [127:0] v);
    logic [127:0] s;
    logic [127:0] c;
    s = 0;
    for (int b = 63; b >= 0; b--) begin
      c = s | (128'd1 << b);
      if (c * c <= v) s = c;
    end
    if (v - s * s > s) s = s + 1;
    return s[63:0];
  endfunction

  function automatic logic signed [127:0] sq_dist(longint ax, longint ay);
    logic signed [127:0] a;
    logic signed [127:0] b;
    a = ax;
    b = ay;
    return a * a + b * b;
  endfunction

  // Offset along one axis: round(dot * d / len2), halves away from zero.
  function automatic longint axis_offset(logic signed [127:0] dot, longint d,
                                         logic signed [127:0] len2);
    logic signed [127:0] num;
    logic signed [127:0] q;
    bit neg;
    num = dot * d;
    neg = num < 0;
    if (neg) num = -num;
    q = (num + (len2 >>> 1)) / len2;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit predict_hit(seg_query_t q);
    longint sx, sy, ex, ey, cx, cy, dx, dy, px, py;
    logic signed [127:0] r2, len2, dot;
    longint unsigned d1, d2, seg_len, dsum;
    sx = q.start_x; sy = q.start_y; ex = q.end_x; ey = q.end_y;
    cx = q.centre_x; cy = q.centre_y;
    r2 = 128'(q.radius) * 128'(q.radius);
    if (sq_dist(sx - cx, sy - cy) <= r2 || sq_dist(ex - cx, ey - cy) <= r2) return 1;
    dx = ex - sx;
    dy = ey - sy;
    len2 = sq_dist(dx, dy);
    if (len2 == 0) return 0;
    dot = 128'(cx - sx) * 128'(dx) + 128'(cy - sy) * 128'(dy);
    px = sx + axis_offset(dot, dx, len2);
    py = sy + axis_offset(dot, dy, len2);
    d1 = round_sqrt(sq_dist(px - sx, py - sy));
    d2 = round_sqrt(sq_dist(px - ex, py - ey));
    seg_len = round_sqrt(len2);
    dsum = d1 + d2;
    if (dsum + tol >= seg_len && dsum <= seg_len + tol)
      return sq_dist(px - cx, py - cy) <= r2;
    return 0;
  endfunction

  function void note_request(seg_query_t q);
    expected_hits.push_back(predict_hit(q));
  endfunction

  function void check_result(bit got, output bit ok, output bit want, output bit orphan);
    orphan = expected_hits.size() == 0;
    ok = 0;
    want = 0;
    if (!orphan) begin
      want = expected_hits.pop_front();
      ok = want == got;
    end
  endfunction
endclass

module testbench;
  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  int in_idle_pct;
  int out_stall_pct;
  int n_fail;
  hit_scoreboard sb;

  scc_in_if #(.CB(24)) in_req ();
  scc_out_if out_req ();

  segment_circle_collision_core uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_req(out_req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop on hang.
  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(string what, bit want, bit got);
    $display("%t ERROR %s: expected hit=%0d got %0d", $time, what, want, got);
    n_fail++;
  endtask

  // Drain results and check against the oldest expectation, with random stalls.
  always @(posedge clk) begin
    bit ok, want, orphan;
    if (rst_n && out_req.valid && out_req.ready) begin
      sb.check_result(out_req.hit, ok, want, orphan);
      if (orphan) report("unexpected result", 0, out_req.hit);
      else if (!ok) report("hit mismatch", want, out_req.hit);
    end
    out_req.ready <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  // Send one request; hold it until accepted, then note it.
  task automatic send_query(seg_query_t q);
    while ($urandom_range(99) < in_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.start_x <= q.start_x;
    in_req.start_y <= q.start_y;
    in_req.end_x <= q.end_x;
    in_req.end_y <= q.end_y;
    in_req.centre_x <= q.centre_x;
    in_req.centre_y <= q.centre_y;
    in_req.radius <= q.radius;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(q);
  endtask

  task automatic go_idle();
    in_req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let the pipeline settle.
  task automatic drain(int limit);
    int waited;
    waited = 0;
    go_idle();
    while (sb.expected_hits.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (70) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tol = v;
    @(posedge clk);
  endtask

  function automatic seg_query_t make_query(int lo, int hi);
    seg_query_t q;
    q.start_x = 24'($urandom_range(hi - lo) + lo);
    q.start_y = 24'($urandom_range(hi - lo) + lo);
    q.end_x = 24'($urandom_range(hi - lo) + lo);
    q.end_y = 24'($urandom_range(hi - lo) + lo);
    q.centre_x = 24'($urandom_range(hi - lo) + lo);
    q.centre_y = 24'($urandom_range(hi - lo) + lo);
    q.radius = 23'($urandom_range(hi - lo) / 2);
    return q;
  endfunction

  // Random query shaped toward near misses and grazing hits.
  function automatic seg_query_t random_query();
    seg_query_t q;
    int mode;
    longint mx, my;
    mode = $urandom_range(5);
    case (mode)
      0: begin
        q.start_x = 24'($urandom); q.start_y = 24'($urandom); q.end_x = 24'($urandom);
        q.end_y = 24'($urandom); q.centre_x = 24'($urandom); q.centre_y = 24'($urandom);
        q.radius = 23'($urandom);
      end
      1: q = make_query(-2000, 2000);
      2: begin
        q = make_query(-100000, 100000);
        mx = (longint'(q.start_x) + q.end_x) / 2;
        my = (longint'(q.start_y) + q.end_y) / 2;
        q.centre_x = 24'(mx + $signed($urandom_range(4000)) - 2000);
        q.centre_y = 24'(my + $signed($urandom_range(4000)) - 2000);
        q.radius = 23'($urandom_range(3000));
      end
      3: begin
        q = make_query(-500, 500);
        q.end_x = q.start_x;
        q.end_y = q.start_y;
      end
      4: begin
        q = make_query(-3000000, 3000000);
        q.radius = 23'($urandom_range(4000000));
      end
      default: begin
        q = make_query(-300, 300);
        q.end_y = 24'(q.start_y + $signed($urandom_range(2)) - 1);
        q.radius = 23'($urandom_range(40));
      end
    endcase
    return q;
  endfunction

  initial begin
    seg_query_t q;
    seg_query_t dq[$];
    logic [15:0] tols[6];
    sb = new();
    n_fail = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.start_x = '0; in_req.start_y = '0; in_req.end_x = '0;
    in_req.end_y = '0; in_req.centre_x = '0; in_req.centre_y = '0;
    in_req.radius = '0;
    out_req.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, endpoint hits, zero length, projection hit and miss.
    q = '{-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607, 24'sd0, 24'sd0, 23'd1};
    dq.push_back(q);
    q = '{24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607,
          -24'sd8388608, -24'sd8388608, 23'h7FFFFF};
    dq.push_back(q);
    q = '{24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607,
          -24'sd8388608, -24'sd8388608, 23'h7FFFFF};
    dq.push_back(q);
    q = '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'd0};
    dq.push_back(q);
    q = '{24'sd10, 24'sd10, 24'sd10, 24'sd10, 24'sd0, 24'sd0, 23'd5};
    dq.push_back(q);
    q = '{-24'sd2560, 24'sd0, 24'sd2560, 24'sd0, 24'sd0, 24'sd256, 23'd256};
    dq.push_back(q);
    q = '{-24'sd2560, 24'sd0, 24'sd2560, 24'sd0, 24'sd0, 24'sd257, 23'd256};
    dq.push_back(q);
    q = '{24'sd2560, 24'sd0, 24'sd3000, 24'sd0, 24'sd0, 24'sd100, 23'd200};
    dq.push_back(q);
    q = '{24'sd0, 24'sd0, 24'sd300, 24'sd0, 24'sd300, 24'sd0, 23'd0};
    dq.push_back(q);
    q = '{-24'sd1, -24'sd1, 24'sd1, 24'sd1, 24'sd1, -24'sd1, 23'd1};
    dq.push_back(q);
    foreach (dq[i]) send_query(dq[i]);
    drain(20000);

    // Tolerance extremes, then random phases at various idle mixes.
    tols = '{16'd0, 16'hFFFF, 16'd26, 16'd1, 16'd300, 16'd26};
    for (int ph = 0; ph < 6; ph++) begin
      write_tolerance(tols[ph]);
      case (ph % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 47; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 47; end
        default: begin in_idle_pct = 13; out_stall_pct = 13; end
      endcase
      for (int i = 0; i < 150; i++) begin
        send_query(random_query());
        // Pause until the pipeline has emptied once mid-phase.
        if (ph == 1 && i == 70) drain(20000);
      end
      drain(200000);
    end

    if (sb.expected_hits.size() != 0) begin
      $display("ERROR %0d results never arrived", sb.expected_hits.size());
      n_fail++;
    end
    if (n_fail == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
